// File: rtl/mip_shower_region_tracker_defines.svh
// ----------------------------------------------------------------------------
// mip shower region tracker assertion macros
// concurrent assertion helpers, empty bodies when synthesizing
// ----------------------------------------------------------------------------
`ifndef MIP_SHOWER_REGION_TRACKER_DEFINES_SVH
`define MIP_SHOWER_REGION_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define SRT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SRT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: rtl/mip_srt_pkg.sv
// ----------------------------------------------------------------------------
// mip shower region tracker package
// shared widths, codes, payload and control structs
// ----------------------------------------------------------------------------
package mip_srt_pkg;

    localparam int LAYER_BITS = 8;
    localparam int CMP_W      = (LAYER_BITS > 8) ? LAYER_BITS : 8;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int WQ_DEPTH   = 2;
    localparam int OQ_DEPTH   = 2;

    localparam logic [LAYER_BITS-1:0] LAYER_UNSET = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIP_RUN_NEEDED       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOWER_RUN_NEEDED    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSED_LAYERS    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MIP2_SPAN        = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SHOWER_BEGIN     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SHOWER_SPAN      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SHOWER_BEGIN_ALT = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SHOWER_SPAN_ALT  = 8'd7;

    typedef enum logic [1:0] {
        MODE_MIP1   = 2'd0,
        MODE_SHOWER = 2'd1,
        MODE_MIP2   = 2'd2
    } t_region;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_MIP    = 2'd1,
        KIND_SHOWER = 2'd2,
        KIND_BOTH   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [LAYER_BITS-1:0] layer;
        logic                  mip_found;
        logic                  shower_found;
        logic                  last_layer;
    } t_in;

    typedef struct packed {
        logic                  fragment;
        logic [LAYER_BITS-1:0] shower_begin;
        logic [LAYER_BITS-1:0] shower_finish;
    } t_out;

    typedef struct packed {
        logic [LAYER_BITS-1:0] layer;
        t_kind                 kind;
        logic                  last_layer;
    } t_work;

    typedef struct packed {
        logic [LAYER_BITS-1:0] mip2_begin;
        logic [LAYER_BITS-1:0] mip2_finish;
        logic [LAYER_BITS-1:0] shower_begin;
        logic [LAYER_BITS-1:0] shower_finish;
    } t_snap;

    typedef struct packed {
        logic [3:0] mip_run_needed;
        logic [3:0] shower_run_needed;
        logic [3:0] max_missed_layers;
        logic [7:0] min_mip2_span;
        logic [7:0] max_shower_begin;
        logic [7:0] min_shower_span;
        logic [7:0] max_shower_begin_alt;
        logic [7:0] min_shower_span_alt;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mip_run_needed:       4'd2,
        shower_run_needed:    4'd2,
        max_missed_layers:    4'd1,
        min_mip2_span:        8'd4,
        max_shower_begin:     8'd20,
        min_shower_span:      8'd4,
        max_shower_begin_alt: 8'd5,
        min_shower_span_alt:  8'd200
    };

endpackage

// File: rtl/mip_shower_region_tracker.sv
// ----------------------------------------------------------------------------
// mip shower region tracker
// follows first mip, shower and second mip regions over a cluster's layers
// ----------------------------------------------------------------------------
// Feed the layers of one cluster in order, one item per layer, through the
// push/full side; the item marked last_layer produces one result on the
// empty/pop side (fragment flag, shower begin and finish layers, all ones when
// not found) and clears the per-cluster state for the next cluster. Layers are
// taken at one per cycle for as long as the result side keeps up: a small work
// queue feeds the region tracker, which updates its registers per layer, and
// the fragment decision is made from the registered snapshot of the layer
// marks and pushed into a two-entry result queue, after the work queue and
// the snapshot register. The only backpressure point is a last layer meeting
// a full result queue. Registers are written through the valid/ready port,
// which is always ready; write them only while no cluster is in flight.
// Unknown register indexes are dropped.
// ----------------------------------------------------------------------------
module mip_shower_region_tracker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // layer items in
    input  logic                                  push,
    output logic                                  full,
    input  mip_srt_pkg::t_in                      i_in,
    // decisions out
    output logic                                  empty,
    input  logic                                  pop,
    output mip_srt_pkg::t_out                     o_out,
    // register writes
    input  logic                                  valid,
    output logic                                  ready,
    input  logic [mip_srt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mip_srt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    mip_srt_pkg::t_cfg  r_cfg, n_cfg;
    logic               w_wk_vld;
    mip_srt_pkg::t_work w_wk;
    logic               w_wk_pop;
    logic               w_snap_vld;
    mip_srt_pkg::t_snap w_snap;
    logic               w_snap_take;

    // register file, writes always accepted
    assign ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (valid) begin
            unique case (i_cfg_index)
                mip_srt_pkg::CFG_MIP_RUN_NEEDED:       n_cfg.mip_run_needed = i_cfg_data[3:0];
                mip_srt_pkg::CFG_SHOWER_RUN_NEEDED:    n_cfg.shower_run_needed = i_cfg_data[3:0];
                mip_srt_pkg::CFG_MAX_MISSED_LAYERS:    n_cfg.max_missed_layers = i_cfg_data[3:0];
                mip_srt_pkg::CFG_MIN_MIP2_SPAN:        n_cfg.min_mip2_span = i_cfg_data[7:0];
                mip_srt_pkg::CFG_MAX_SHOWER_BEGIN:     n_cfg.max_shower_begin = i_cfg_data[7:0];
                mip_srt_pkg::CFG_MIN_SHOWER_SPAN:      n_cfg.min_shower_span = i_cfg_data[7:0];
                mip_srt_pkg::CFG_MAX_SHOWER_BEGIN_ALT: n_cfg.max_shower_begin_alt = i_cfg_data[7:0];
                mip_srt_pkg::CFG_MIN_SHOWER_SPAN_ALT:  n_cfg.min_shower_span_alt = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= mip_srt_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: accept and classify layers
    mip_srt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_in     (i_in),
        .o_wk_vld (w_wk_vld),
        .o_wk     (w_wk),
        .i_wk_pop (w_wk_pop)
    );

    // back: region tracking per layer
    mip_srt_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_wk_vld    (w_wk_vld),
        .i_wk        (w_wk),
        .o_wk_pop    (w_wk_pop),
        .o_snap_vld  (w_snap_vld),
        .o_snap      (w_snap),
        .i_snap_take (w_snap_take)
    );

    // back: fragment decision and result queue
    mip_srt_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_snap_vld  (w_snap_vld),
        .i_snap      (w_snap),
        .o_snap_take (w_snap_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

endmodule

// File: rtl/mip_srt_front.sv
// ----------------------------------------------------------------------------
// mip shower region tracker front end
// accepts layer items, classifies the hit flags, queues work for the tracker
// ----------------------------------------------------------------------------
`include "mip_shower_region_tracker_defines.svh"

module mip_srt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  mip_srt_pkg::t_in   i_in,
    output logic               o_wk_vld,
    output mip_srt_pkg::t_work o_wk,
    input  logic               i_wk_pop
);

    localparam int DEPTH = mip_srt_pkg::WQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mip_srt_pkg::t_work r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    mip_srt_pkg::t_work w_cls;
    logic               w_wr;
    logic               w_rd;

    // hit flag classification
    always_comb begin
        w_cls.layer      = i_in.layer;
        w_cls.last_layer = i_in.last_layer;
        unique case ({i_in.mip_found, i_in.shower_found})
            2'b10:   w_cls.kind = mip_srt_pkg::KIND_MIP;
            2'b01:   w_cls.kind = mip_srt_pkg::KIND_SHOWER;
            2'b11:   w_cls.kind = mip_srt_pkg::KIND_BOTH;
            default: w_cls.kind = mip_srt_pkg::KIND_NONE;
        endcase
    end

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_wk_vld = (r_count != '0);
    assign o_wk     = r_mem[r_rd_ptr];
    assign w_wr     = i_push && !o_full;
    assign w_rd     = i_wk_pop && o_wk_vld;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(w_wr) - CNT_W'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

    `SRT_ASSERT(a_front_push_counts, i_clk, i_rst_n, (w_wr && !w_rd) |=> (r_count == $past(r_count) + 1'b1), "front queue count did not follow a push")

endmodule

// File: rtl/mip_srt_track.sv
// ----------------------------------------------------------------------------
// mip shower region tracker region state
// per-layer region update, snapshot of the layer marks on the last layer
// ----------------------------------------------------------------------------
`include "mip_shower_region_tracker_defines.svh"

module mip_srt_track (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mip_srt_pkg::t_cfg  i_cfg,
    input  logic               i_wk_vld,
    input  mip_srt_pkg::t_work i_wk,
    output logic               o_wk_pop,
    output logic               o_snap_vld,
    output mip_srt_pkg::t_snap o_snap,
    input  logic               i_snap_take
);

    localparam int LW = mip_srt_pkg::LAYER_BITS;
    localparam int CW = mip_srt_pkg::CNT_W;

    mip_srt_pkg::t_region r_mode, n_mode;
    logic                 r_stopped, n_stopped;
    logic [CW-1:0]        r_missed, n_missed;
    logic [CW-1:0]        r_mip_run, n_mip_run;
    logic [CW-1:0]        r_shower_run, n_shower_run;
    logic [LW-1:0]        r_m2b, n_m2b;
    logic [LW-1:0]        r_m2f, n_m2f;
    logic [LW-1:0]        r_sb, n_sb;
    logic [LW-1:0]        r_sf, n_sf;
    logic                 r_snap_vld, n_snap_vld;
    mip_srt_pkg::t_snap   r_snap, n_snap;

    mip_srt_pkg::t_region u_mode;
    logic                 u_stopped;
    logic [CW-1:0]        u_missed, u_mip_run, u_shower_run;
    logic [LW-1:0]        u_m2b, u_m2f, u_sb, u_sf;
    logic [CW-1:0]        w_inc;
    logic                 w_mip, w_shw;
    logic                 w_take;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    assign w_mip = (i_wk.kind == mip_srt_pkg::KIND_MIP) ||
                   (i_wk.kind == mip_srt_pkg::KIND_BOTH);
    assign w_shw = (i_wk.kind == mip_srt_pkg::KIND_SHOWER) ||
                   (i_wk.kind == mip_srt_pkg::KIND_BOTH);

    // a last layer waits while the previous snapshot is still held
    assign w_take   = i_wk_vld && (!i_wk.last_layer || !r_snap_vld || i_snap_take);
    assign o_wk_pop = w_take;

    // region update for one layer
    always_comb begin
        u_mode       = r_mode;
        u_stopped    = r_stopped;
        u_missed     = r_missed;
        u_mip_run    = r_mip_run;
        u_shower_run = r_shower_run;
        u_m2b        = r_m2b;
        u_m2f        = r_m2f;
        u_sb         = r_sb;
        u_sf         = r_sf;
        w_inc        = '0;
        if (!r_stopped) begin
            u_missed = (w_mip || w_shw) ? '0 : sat_inc(r_missed);
            if (w_mip && r_mode == mip_srt_pkg::MODE_MIP2) begin
                u_m2f = i_wk.layer;
            end
            if (w_shw && r_mode == mip_srt_pkg::MODE_SHOWER) begin
                u_sf = i_wk.layer;
            end
            case (i_wk.kind)
                mip_srt_pkg::KIND_MIP: begin
                    case (r_mode) inside
                        mip_srt_pkg::MODE_MIP1, mip_srt_pkg::MODE_MIP2: begin
                            u_shower_run = '0;
                        end
                        mip_srt_pkg::MODE_SHOWER: begin
                            w_inc     = sat_inc(r_mip_run);
                            u_mip_run = w_inc;
                            if (w_inc == CW'(i_cfg.mip_run_needed)) begin
                                u_mode       = mip_srt_pkg::MODE_MIP2;
                                u_shower_run = '0;
                            end else begin
                                u_m2b = i_wk.layer;
                            end
                        end
                        default: ;
                    endcase
                end
                mip_srt_pkg::KIND_SHOWER: begin
                    case (r_mode) inside
                        mip_srt_pkg::MODE_SHOWER: begin
                            u_mip_run = '0;
                        end
                        mip_srt_pkg::MODE_MIP1, mip_srt_pkg::MODE_MIP2: begin
                            w_inc        = sat_inc(r_shower_run);
                            u_shower_run = w_inc;
                            if (w_inc == CW'(i_cfg.shower_run_needed)) begin
                                if (r_mode == mip_srt_pkg::MODE_MIP1) begin
                                    u_mode       = mip_srt_pkg::MODE_SHOWER;
                                    u_shower_run = '0;
                                end else begin
                                    u_stopped = 1'b1;
                                end
                            end else if (r_mode == mip_srt_pkg::MODE_MIP1) begin
                                u_sb = i_wk.layer;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (u_missed > CW'(i_cfg.max_missed_layers)) begin
                u_stopped = 1'b1;
            end
        end
    end

    // commit, and clear the cluster after its last layer
    always_comb begin
        n_mode       = r_mode;
        n_stopped    = r_stopped;
        n_missed     = r_missed;
        n_mip_run    = r_mip_run;
        n_shower_run = r_shower_run;
        n_m2b        = r_m2b;
        n_m2f        = r_m2f;
        n_sb         = r_sb;
        n_sf         = r_sf;
        n_snap_vld   = r_snap_vld && !i_snap_take;
        n_snap       = r_snap;
        if (w_take) begin
            if (i_wk.last_layer) begin
                n_snap_vld          = 1'b1;
                n_snap.mip2_begin    = u_m2b;
                n_snap.mip2_finish   = u_m2f;
                n_snap.shower_begin  = u_sb;
                n_snap.shower_finish = u_sf;
                n_mode       = mip_srt_pkg::MODE_MIP1;
                n_stopped    = 1'b0;
                n_missed     = '0;
                n_mip_run    = '0;
                n_shower_run = '0;
                n_m2b        = mip_srt_pkg::LAYER_UNSET;
                n_m2f        = mip_srt_pkg::LAYER_UNSET;
                n_sb         = mip_srt_pkg::LAYER_UNSET;
                n_sf         = mip_srt_pkg::LAYER_UNSET;
            end else begin
                n_mode       = u_mode;
                n_stopped    = u_stopped;
                n_missed     = u_missed;
                n_mip_run    = u_mip_run;
                n_shower_run = u_shower_run;
                n_m2b        = u_m2b;
                n_m2f        = u_m2f;
                n_sb         = u_sb;
                n_sf         = u_sf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= mip_srt_pkg::MODE_MIP1;
            r_stopped    <= 1'b0;
            r_missed     <= '0;
            r_mip_run    <= '0;
            r_shower_run <= '0;
            r_m2b        <= mip_srt_pkg::LAYER_UNSET;
            r_m2f        <= mip_srt_pkg::LAYER_UNSET;
            r_sb         <= mip_srt_pkg::LAYER_UNSET;
            r_sf         <= mip_srt_pkg::LAYER_UNSET;
            r_snap_vld   <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_stopped    <= n_stopped;
            r_missed     <= n_missed;
            r_mip_run    <= n_mip_run;
            r_shower_run <= n_shower_run;
            r_m2b        <= n_m2b;
            r_m2f        <= n_m2f;
            r_sb         <= n_sb;
            r_sf         <= n_sf;
            r_snap_vld   <= n_snap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

    `SRT_ASSERT(a_track_stop_holds, i_clk, i_rst_n, (r_stopped && !(w_take && i_wk.last_layer)) |=> r_stopped, "tracking restarted inside a cluster")
    `SRT_ASSERT(a_track_clear_after_last, i_clk, i_rst_n, (w_take && i_wk.last_layer) |=> (r_mode == mip_srt_pkg::MODE_MIP1 && !r_stopped && r_sf == mip_srt_pkg::LAYER_UNSET), "cluster state not cleared after last layer")
    `SRT_ASSERT_NEVER(a_track_snap_overrun, i_clk, i_rst_n, w_take && i_wk.last_layer && r_snap_vld && !i_snap_take, "snapshot overwritten before taken")

endmodule

// File: rtl/mip_srt_decide.sv
// ----------------------------------------------------------------------------
// mip shower region tracker decision stage
// fragment decision from the cluster snapshot, result queue
// ----------------------------------------------------------------------------
`include "mip_shower_region_tracker_defines.svh"

module mip_srt_decide (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mip_srt_pkg::t_cfg  i_cfg,
    input  logic               i_snap_vld,
    input  mip_srt_pkg::t_snap i_snap,
    output logic               o_snap_take,
    output logic               o_empty,
    input  logic               i_pop,
    output mip_srt_pkg::t_out  o_out
);

    localparam int LW    = mip_srt_pkg::LAYER_BITS;
    localparam int CMW   = mip_srt_pkg::CMP_W;
    localparam int DEPTH = mip_srt_pkg::OQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mip_srt_pkg::t_out r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    mip_srt_pkg::t_out w_res;
    logic              w_m2_span, w_sh_span, w_sh_span_alt;
    logic              w_sb_lt, w_sb_lt_alt;
    logic              w_rd;

    // both ends set, end not below start, distance above the limit
    function automatic logic span_exceeds(input logic [LW-1:0] s, input logic [LW-1:0] f,
                                          input logic [7:0] limit);
        logic [LW-1:0] diff;
        diff = f - s;
        if (s == mip_srt_pkg::LAYER_UNSET || f == mip_srt_pkg::LAYER_UNSET || f < s) begin
            return 1'b0;
        end
        return CMW'(diff) > CMW'(limit);
    endfunction

    assign w_m2_span     = span_exceeds(i_snap.mip2_begin, i_snap.mip2_finish,
                                        i_cfg.min_mip2_span);
    assign w_sh_span     = span_exceeds(i_snap.shower_begin, i_snap.shower_finish,
                                        i_cfg.min_shower_span);
    assign w_sh_span_alt = span_exceeds(i_snap.shower_begin, i_snap.shower_finish,
                                        i_cfg.min_shower_span_alt);
    assign w_sb_lt       = CMW'(i_snap.shower_begin) < CMW'(i_cfg.max_shower_begin);
    assign w_sb_lt_alt   = CMW'(i_snap.shower_begin) < CMW'(i_cfg.max_shower_begin_alt);

    always_comb begin
        w_res.shower_begin  = i_snap.shower_begin;
        w_res.shower_finish = i_snap.shower_finish;
        if (i_snap.mip2_finish == mip_srt_pkg::LAYER_UNSET) begin
            w_res.fragment = 1'b0;
        end else if (i_snap.shower_finish != mip_srt_pkg::LAYER_UNSET &&
                     i_snap.shower_begin == mip_srt_pkg::LAYER_UNSET) begin
            w_res.fragment = 1'b1;
        end else begin
            w_res.fragment = (w_m2_span && w_sb_lt && w_sh_span) ||
                             (w_sb_lt_alt && w_sh_span_alt);
        end
    end

    assign o_snap_take = i_snap_vld && (r_count != CNT_W'(DEPTH));
    assign o_empty     = (r_count == '0);
    assign o_out       = r_mem[r_rd_ptr];
    assign w_rd        = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (o_snap_take) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(o_snap_take) - CNT_W'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_mem[r_wr_ptr] <= w_res;
        end
    end

    `SRT_ASSERT_NEVER(a_decide_count_bound, i_clk, i_rst_n, r_count > CNT_W'(DEPTH), "result queue count beyond depth")

endmodule
